// ===== rtl/nearest_neighbour_image_scaler_unit_assert.svh =====
// Assertion macros used by the scaler datapath.
// Each macro samples on the rising edge of clk and is disabled during rst.
`ifndef NEAREST_NEIGHBOUR_IMAGE_SCALER_UNIT_ASSERT_SVH
`define NEAREST_NEIGHBOUR_IMAGE_SCALER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define NNIS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define NNIS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/nnis_pkg.sv =====
package nnis_pkg;

  localparam int MAX_SRC_DIM_DEF    = 256;
  localparam int MAX_DST_DIM_DEF    = 4096;
  localparam int STEP_FRAC_BITS_DEF = 16;

  localparam int PIX_BYTES  = 4;
  localparam int PIX_W      = 8 * PIX_BYTES;
  localparam int SRC_CFG_W  = 9;
  localparam int DST_CFG_W  = 13;
  localparam int STEP_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOURCE_WIDTH  = 3'd0,
    REG_SOURCE_HEIGHT = 3'd1,
    REG_TARGET_WIDTH  = 3'd2,
    REG_TARGET_HEIGHT = 3'd3,
    REG_STEP_X        = 3'd4,
    REG_STEP_Y        = 3'd5
  } reg_idx_t;

  // Request function codes.
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_EMIT = 1'b1;

  typedef struct packed {
    logic             func;
    logic [PIX_W-1:0] pixel_in;
  } item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             frame_last;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_LOAD_DIV,
    ST_MUL,
    ST_MAG,
    ST_MAP,
    ST_MAP_DIV,
    ST_ROW,
    ST_READ,
    ST_SEND
  } ctrl_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;        // latch the accepted request and the normalized counters
    logic load_write;     // write the held pixel into the store
    logic load_from_rem;  // take the store address from the remainder unit
    logic div_start;      // start the remainder unit
    logic div_load;       // remainder operands: load pointer / frame size
    logic axis;           // 0: column, 1: row
    logic mul;            // register coordinate times step
    logic mag;            // register magnitude of the product
    logic map_set;        // register mapped coordinate, no division needed
    logic map_fix;        // register mapped coordinate from the remainder
    logic row_mul;        // register row base address
    logic rd_issue;       // read the store
    logic deliver;        // load the result register, advance the counters
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic item_func;
    logic dst_empty;
    logic ptr_ge_frame;
    logic need_div;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/nearest_neighbour_image_scaler_unit.sv =====
// Load request: accept, then store write; after a source resize that leaves the
//   load pointer outside the frame, the shared remainder unit wraps it first.
// Emit request: accept, column map, row map, row base, store read, result hand-off; each
//   axis whose step is negative and wraps past the source size adds a remainder pass.
// The rate is set by the single shared multiplier, used for column then row, and the
//   one-port store read. Reset is synchronous and active high: clears counters, pointer,
//   handshake state and config to defaults; store contents stay undefined until loaded.
module nearest_neighbour_image_scaler_unit #(
  parameter int MAX_SRC_DIM    = nnis_pkg::MAX_SRC_DIM_DEF,
  parameter int MAX_DST_DIM    = nnis_pkg::MAX_DST_DIM_DEF,
  parameter int STEP_FRAC_BITS = nnis_pkg::STEP_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // Request channel: load a source pixel or emit the next destination pixel.
  input  logic                            item_valid,
  output logic                            item_ready,
  input  nnis_pkg::item_t                 item,
  // Result channel: one destination pixel per non-empty emit request.
  output logic                            result_valid,
  input  logic                            result_ready,
  output nnis_pkg::result_t               result,
  // Configuration write channel.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [nnis_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nnis_pkg::CFG_DATA_W-1:0] cfg_data
);

  import nnis_pkg::*;

  // Command and status between the sequencer and the datapath.
  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequence each request: accept in idle, then either write the store (load)
  // or run column map, row map, row base, store read and result hand-off (emit).
  // The result register decouples the sides, so the next request is taken
  // while a finished pixel still waits downstream.
  nnis_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .status     (status),
    .cmd        (cmd)
  );

  // Hold config, counters, load pointer, the mapping arithmetic, the shared
  // remainder unit, the frame store and the result register.
  nnis_datapath #(
    .MAX_SRC_DIM    (MAX_SRC_DIM),
    .MAX_DST_DIM    (MAX_DST_DIM),
    .STEP_FRAC_BITS (STEP_FRAC_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .status       (status)
  );

endmodule

// ===== rtl/nnis_ram.sv =====
module nnis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/nnis_rem.sv =====
module nnis_rem #(
  parameter int DIVIDEND_W = 27,
  parameter int DIVISOR_W  = 17
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVISOR_W-1:0]  remainder
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy;
  logic [CNT_W-1:0]      cnt;
  logic [DIVIDEND_W-1:0] num;
  logic [DIVISOR_W-1:0]  den;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    trial_sub;
  logic [DIVISOR_W-1:0]  rem_next;

  // Restoring remainder, one dividend bit a cycle, MSB first.
  always_comb begin
    trial     = {rem, num[DIVIDEND_W-1]};
    trial_sub = trial - {1'b0, den};
    if (trial >= {1'b0, den}) begin
      rem_next = trial_sub[DIVISOR_W-1:0];
    end else begin
      rem_next = trial[DIVISOR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIVIDEND_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      den <= divisor;
      rem <= '0;
    end else if (busy) begin
      num <= num << 1;
      rem <= rem_next;
    end
  end

  assign remainder = rem;

endmodule

// ===== rtl/nnis_ctrl.sv =====
module nnis_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  nnis_pkg::dp_status_t status,
  output nnis_pkg::dp_cmd_t    cmd
);

  import nnis_pkg::*;

  ctrl_state_t state, state_next;
  logic        axis, axis_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      axis  <= 1'b0;
    end else begin
      state <= state_next;
      axis  <= axis_next;
    end
  end

  always_comb begin
    state_next = state;
    axis_next  = axis;
    item_ready = 1'b0;
    cmd        = '0;
    cmd.axis   = axis;
    unique case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.capture = 1'b1;
          axis_next   = 1'b0;
          if (status.item_func == FUNC_LOAD) begin
            state_next = ST_LOAD;
          end else if (!status.dst_empty) begin
            state_next = ST_MUL;
          end
        end
      end
      ST_LOAD: begin
        cmd.div_load = 1'b1;
        if (status.ptr_ge_frame) begin
          cmd.div_start = 1'b1;
          state_next    = ST_LOAD_DIV;
        end else begin
          cmd.load_write = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      ST_LOAD_DIV: begin
        cmd.div_load = 1'b1;
        if (status.div_done) begin
          cmd.load_write    = 1'b1;
          cmd.load_from_rem = 1'b1;
          state_next        = ST_IDLE;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_MAG;
      end
      ST_MAG: begin
        cmd.mag    = 1'b1;
        state_next = ST_MAP;
      end
      ST_MAP: begin
        if (status.need_div) begin
          cmd.div_start = 1'b1;
          state_next    = ST_MAP_DIV;
        end else begin
          cmd.map_set = 1'b1;
          axis_next   = 1'b1;
          state_next  = axis ? ST_ROW : ST_MUL;
        end
      end
      ST_MAP_DIV: begin
        if (status.div_done) begin
          cmd.map_fix = 1'b1;
          axis_next   = 1'b1;
          state_next  = axis ? ST_ROW : ST_MUL;
        end
      end
      ST_ROW: begin
        cmd.row_mul = 1'b1;
        state_next  = ST_READ;
      end
      ST_READ: begin
        cmd.rd_issue = 1'b1;
        state_next   = ST_SEND;
      end
      ST_SEND: begin
        if (status.out_free) begin
          cmd.deliver = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/nnis_datapath.sv =====
`include "nearest_neighbour_image_scaler_unit_assert.svh"

module nnis_datapath #(
  parameter int MAX_SRC_DIM    = nnis_pkg::MAX_SRC_DIM_DEF,
  parameter int MAX_DST_DIM    = nnis_pkg::MAX_DST_DIM_DEF,
  parameter int STEP_FRAC_BITS = nnis_pkg::STEP_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  nnis_pkg::item_t                     item,
  output nnis_pkg::result_t                   result,
  output logic                                result_valid,
  input  logic                                result_ready,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [nnis_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [nnis_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  nnis_pkg::dp_cmd_t                   cmd,
  output nnis_pkg::dp_status_t                status
);

  import nnis_pkg::*;

  localparam int CW    = (MAX_DST_DIM > 1) ? $clog2(MAX_DST_DIM) : 1;
  localparam int TDW   = $clog2(MAX_DST_DIM + 1);
  localparam int SCW   = (MAX_SRC_DIM > 1) ? $clog2(MAX_SRC_DIM) : 1;
  localparam int SZW   = $clog2(MAX_SRC_DIM + 1);
  localparam int DEPTH = MAX_SRC_DIM * MAX_SRC_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW    = $clog2(DEPTH + 1);
  localparam int PW    = CW + 1 + STEP_W;
  localparam int MAGW  = CW + STEP_W - 1 - STEP_FRAC_BITS;
  localparam int DVW   = (AW > MAGW) ? AW : MAGW;

  // Configuration registers.
  logic [SRC_CFG_W-1:0]     source_width;
  logic [SRC_CFG_W-1:0]     source_height;
  logic [DST_CFG_W-1:0]     target_width;
  logic [DST_CFG_W-1:0]     target_height;
  logic signed [STEP_W-1:0] step_x;
  logic signed [STEP_W-1:0] step_y;

  // Control state.
  logic [AW-1:0] load_pointer;
  logic [CW-1:0] out_column;
  logic [CW-1:0] out_row;

  // Work registers.
  logic [PIX_W-1:0]     pixel_hold;
  logic [CW-1:0]        norm_col;
  logic [CW-1:0]        norm_row;
  logic signed [PW-1:0] prod;
  logic [MAGW-1:0]      mag;
  logic                 neg;
  logic [SCW-1:0]       sx;
  logic [SCW-1:0]       sy;
  logic [AW-1:0]        row_base;

  // Combinational signals.
  logic [SZW-1:0]     eff_sw;
  logic [SZW-1:0]     eff_sh;
  logic [TDW-1:0]     eff_tw;
  logic [TDW-1:0]     eff_th;
  logic [FW-1:0]      frame;
  logic               col_ge;
  logic [CW:0]        row_inc;
  logic [CW-1:0]      norm_col_w;
  logic [CW-1:0]      norm_row_w;
  logic [CW:0]        col_inc;
  logic [CW:0]        row_step;
  logic               col_wrap;
  logic               row_wrap;
  logic               last_w;
  logic [CW-1:0]      mul_pos;
  logic signed [STEP_W-1:0] mul_step;
  logic [PW-1:0]      abs_prod;
  logic [SZW-1:0]     size;
  logic [SZW-1:0]     size_m1;
  logic [SCW-1:0]     coord_set;
  logic [SCW-1:0]     coord_fix;
  logic [FW-1:0]      div_rem;
  logic               div_done;
  logic [DVW-1:0]     div_dividend;
  logic [FW-1:0]      div_divisor;
  logic [AW-1:0]      wr_addr;
  logic [FW-1:0]      ptr_inc;
  logic [AW-1:0]      rd_addr;
  logic [PIX_W-1:0]   rd_data;

  function automatic logic [SZW-1:0] eff_src(input logic [SRC_CFG_W-1:0] v);
    logic [SZW-1:0] r;
    if (v == '0) begin
      r = SZW'(1);
    end else if (32'(v) > MAX_SRC_DIM) begin
      r = SZW'(MAX_SRC_DIM);
    end else begin
      r = SZW'(v);
    end
    return r;
  endfunction

  function automatic logic [TDW-1:0] eff_dst(input logic [DST_CFG_W-1:0] v);
    logic [TDW-1:0] r;
    if (32'(v) > MAX_DST_DIM) begin
      r = TDW'(MAX_DST_DIM);
    end else begin
      r = TDW'(v);
    end
    return r;
  endfunction

  assign eff_sw = eff_src(source_width);
  assign eff_sh = eff_src(source_height);
  assign eff_tw = eff_dst(target_width);
  assign eff_th = eff_dst(target_height);
  assign frame  = FW'(eff_sw) * FW'(eff_sh);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= SRC_CFG_W'(1);
      source_height <= SRC_CFG_W'(1);
      target_width  <= '0;
      target_height <= '0;
      step_x        <= STEP_W'(1) <<< STEP_FRAC_BITS;
      step_y        <= STEP_W'(1) <<< STEP_FRAC_BITS;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SOURCE_WIDTH:  source_width  <= cfg_data[SRC_CFG_W-1:0];
        REG_SOURCE_HEIGHT: source_height <= cfg_data[SRC_CFG_W-1:0];
        REG_TARGET_WIDTH:  target_width  <= cfg_data[DST_CFG_W-1:0];
        REG_TARGET_HEIGHT: target_height <= cfg_data[DST_CFG_W-1:0];
        REG_STEP_X:        step_x        <= cfg_data[STEP_W-1:0];
        REG_STEP_Y:        step_y        <= cfg_data[STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Counters that ran past a shrunken target restart on the next row / frame.
  always_comb begin
    col_ge     = out_column >= eff_tw;
    row_inc    = col_ge ? ({1'b0, out_row} + 1'b1) : {1'b0, out_row};
    norm_col_w = col_ge ? '0 : out_column;
    norm_row_w = (row_inc >= eff_th) ? '0 : row_inc[CW-1:0];
  end

  // Advance past the current pixel.
  always_comb begin
    col_inc  = {1'b0, norm_col} + 1'b1;
    row_step = {1'b0, norm_row} + 1'b1;
    col_wrap = col_inc >= eff_tw;
    row_wrap = row_step >= eff_th;
    last_w   = col_wrap && row_wrap;
  end

  // Coordinate mapping.
  always_comb begin
    mul_pos  = cmd.axis ? norm_row : norm_col;
    mul_step = cmd.axis ? step_y : step_x;
    abs_prod = prod[PW-1] ? PW'(-prod) : PW'(prod);
    size     = cmd.axis ? eff_sh : eff_sw;
    size_m1  = size - 1'b1;
    if (!neg) begin
      coord_set = (mag > size_m1) ? SCW'(size_m1) : SCW'(mag);
    end else if (mag == '0) begin
      coord_set = '0;
    end else begin
      coord_set = SCW'(size - SZW'(mag));
    end
    coord_fix = (div_rem == '0) ? '0 : SCW'(FW'(size) - div_rem);
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pixel_hold <= item.pixel_in;
      norm_col   <= norm_col_w;
      norm_row   <= norm_row_w;
    end
    if (cmd.mul) begin
      prod <= PW'($signed({1'b0, mul_pos})) * PW'(mul_step);
    end
    if (cmd.mag) begin
      mag <= abs_prod[STEP_FRAC_BITS +: MAGW];
      neg <= prod[PW-1];
    end
    if (cmd.map_set || cmd.map_fix) begin
      if (cmd.axis) begin
        sy <= cmd.map_set ? coord_set : coord_fix;
      end else begin
        sx <= cmd.map_set ? coord_set : coord_fix;
      end
    end
    if (cmd.row_mul) begin
      row_base <= AW'(sy) * AW'(eff_sw);
    end
    if (cmd.deliver) begin
      result.pixel_out  <= rd_data;
      result.frame_last <= last_w;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_pointer <= '0;
      out_column   <= '0;
      out_row      <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.load_write) begin
        load_pointer <= (ptr_inc >= frame) ? '0 : AW'(ptr_inc);
      end
      if (cmd.deliver) begin
        if (col_wrap) begin
          out_column <= '0;
          out_row    <= row_wrap ? '0 : row_step[CW-1:0];
        end else begin
          out_column <= col_inc[CW-1:0];
          out_row    <= norm_row;
        end
      end
      if (cmd.deliver) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Shared remainder unit: load pointer wrap and negative index wrap.
  assign div_dividend = cmd.div_load ? DVW'(load_pointer) : DVW'(mag);
  assign div_divisor  = cmd.div_load ? frame : FW'(size);

  nnis_rem #(
    .DIVIDEND_W (DVW),
    .DIVISOR_W  (FW)
  ) u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .remainder (div_rem)
  );

  assign wr_addr = cmd.load_from_rem ? AW'(div_rem) : load_pointer;
  assign ptr_inc = FW'(wr_addr) + 1'b1;
  assign rd_addr = row_base + AW'(sx);

  nnis_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.load_write),
    .wr_addr (wr_addr),
    .wr_data (pixel_hold),
    .rd_en   (cmd.rd_issue),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    status.item_func    = item.func;
    status.dst_empty    = (eff_tw == '0) || (eff_th == '0);
    status.ptr_ge_frame = FW'(load_pointer) >= frame;
    status.need_div     = neg && (mag >= size);
    status.div_done     = div_done;
    status.out_free     = !result_valid || result_ready;
  end

  `NNIS_ASSERT_IMP(a_deliver_slot_free, cmd.deliver, !result_valid || result_ready,
                   "result overwritten before it was taken")
  `NNIS_ASSERT_IMP(a_load_addr_in_frame, cmd.load_write, FW'(wr_addr) < frame,
                   "store write outside the source frame")
  `NNIS_ASSERT_IMP(a_read_addr_in_frame, cmd.rd_issue, FW'(rd_addr) < frame,
                   "store read outside the source frame")
  `NNIS_ASSERT_NXT(a_frame_end_restart, cmd.deliver && last_w,
                   out_column == '0 && out_row == '0,
                   "counters did not restart after the last frame pixel")

endmodule
